// ===== sv/tpgs_pkg.sv =====
// ============================================================================
// tpgs_pkg
// Shared types, constants and elaboration-time helpers for the prior
// gradient stencil: neighbor offsets, tanh table generation, config codes.
// ============================================================================
`default_nettype none

package tpgs_pkg;

    // Field widths
    localparam int W_VAL  = 24;
    localparam int W_WORD = 25;
    localparam int W_CFG  = 9;
    localparam int W_INVD = 16;
    localparam int W_GRAD = 17;
    localparam int W_TAB  = 13;
    localparam int W_CIDX = 2;

    // Parameter defaults
    localparam int P_MAX_ROW_LEN  = 256;
    localparam int P_MAX_ROWS     = 256;
    localparam int P_TANH_ENTRIES = 1024;

    // Fixed constants
    localparam int           X_MAX       = 256;
    localparam int           SIZE_MIN    = 3;
    localparam int           NB_TAPS     = 19;      // centre plus 18 neighbors
    localparam int           K_W         = 5;
    localparam int           FIRST_EDGE  = 7;       // taps from here on are edge neighbors
    localparam logic [15:0]  EDGE_WEIGHT = 16'd46341;
    localparam int           ONE_Q12     = 4096;
    localparam int           DOUBLINGS   = 12;
    localparam logic [8:0]   RST_SIZE    = 9'd256;
    localparam logic [15:0]  RST_INVD    = 16'd4096;

    // Config register indexes
    typedef enum logic [W_CIDX-1:0] {
        CFG_X_SIZE    = 2'd0,
        CFG_Y_SIZE    = 2'd1,
        CFG_Z_SIZE    = 2'd2,
        CFG_INV_DELTA = 2'd3
    } t_cfg_idx;

    // One history word handed from the memory to the tanh accumulator
    typedef struct packed {
        logic              valid;
        logic              centre;
        logic              last;
        logic              edge_nb;
        logic              interior;
        logic [W_WORD-1:0] word;
    } t_acc_in;

    // Neighbor displacement per tap; tap 0 is the centre itself
    function automatic logic signed [1:0] nb_dx(input logic [K_W-1:0] k);
        case (k)
            5'd3, 5'd7, 5'd9, 5'd15, 5'd16:  nb_dx = -2'sd1;
            5'd4, 5'd8, 5'd10, 5'd17, 5'd18: nb_dx = 2'sd1;
            default:                         nb_dx = 2'sd0;
        endcase
    endfunction

    function automatic logic signed [1:0] nb_dy(input logic [K_W-1:0] k);
        case (k)
            5'd5, 5'd11, 5'd13, 5'd15, 5'd17: nb_dy = -2'sd1;
            5'd6, 5'd12, 5'd14, 5'd16, 5'd18: nb_dy = 2'sd1;
            default:                          nb_dy = 2'sd0;
        endcase
    endfunction

    function automatic logic signed [1:0] nb_dz(input logic [K_W-1:0] k);
        case (k)
            5'd1, 5'd7, 5'd8, 5'd11, 5'd12:  nb_dz = -2'sd1;
            5'd2, 5'd9, 5'd10, 5'd13, 5'd14: nb_dz = 2'sd1;
            default:                         nb_dz = 2'sd0;
        endcase
    endfunction

    // Restoring shift-subtract divide, elaboration use only
    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] d);
        logic [63:0] rem;
        logic [63:0] q;
        int          b;
        rem = '0;
        q   = '0;
        for (b = 63; b >= 0; b--) begin
            rem = {rem[62:0], a[b]};
            if (rem >= d) begin
                rem  = rem - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // tanh(8*i/n) in Q12: cubic series at 1/4096 then 12 doublings in Q30
    function automatic logic [63:0] tanh_entry(input int i, input int n);
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] t3;
        logic [63:0] q;
        int          k;
        t  = udiv64((64'(i) << 21) + (64'(n) >> 1), 64'(n));
        t2 = (t * t) >> 30;
        t3 = (t2 * t) >> 30;
        t  = t - t3 / 3;
        for (k = 0; k < DOUBLINGS; k++) begin
            t = udiv64(t << 31, (64'd1 << 30) + ((t * t) >> 30));
        end
        q = (t + (64'd1 << 17)) >> 18;
        if (q > 64'(ONE_Q12)) q = 64'(ONE_Q12);
        return q;
    endfunction

endpackage

`default_nettype wire

// ===== sv/tpgs_in_if.sv =====
// ============================================================================
// tpgs_in_if
// Voxel request channel: valid/ready with value and window flag.
// ============================================================================
`default_nettype none

interface tpgs_in_if
    import tpgs_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [W_VAL-1:0] voxel_value;
    logic             in_window;

    modport source (output valid, output voxel_value, output in_window, input ready);
    modport sink   (input valid, input voxel_value, input in_window, output ready);
endinterface

`default_nettype wire

// ===== sv/tpgs_out_if.sv =====
// ============================================================================
// tpgs_out_if
// Result channel: valid/ready with gradient and real-voxel flag.
// ============================================================================
`default_nettype none

interface tpgs_out_if
    import tpgs_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [W_GRAD-1:0] prior_gradient;
    logic                     voxel_result;

    modport source (output valid, output prior_gradient, output voxel_result, input ready);
    modport sink   (input valid, input prior_gradient, input voxel_result, output ready);
endinterface

`default_nettype wire

// ===== sv/tpgs_hist_mem.sv =====
// ============================================================================
// tpgs_hist_mem
// Voxel history store: one write port, one read port, registered read data.
// ============================================================================
`default_nettype none

module tpgs_hist_mem
    import tpgs_pkg::*;
#(
    parameter int DEPTH = 131587,
    parameter int AW    = 18
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire logic [W_WORD-1:0] i_wdata,
    input  wire logic [AW-1:0]     i_raddr,
    output logic      [W_WORD-1:0] o_rdata
);

    logic [W_WORD-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== sv/tpgs_tanh_acc.sv =====
// ============================================================================
// tpgs_tanh_acc
// Per-neighbor difference, tanh table lookup and face/edge accumulation,
// then edge weighting, saturation and a held result.
// ============================================================================
`default_nettype none

module tpgs_tanh_acc
    import tpgs_pkg::*;
#(
    parameter int TANH_ENTRIES = P_TANH_ENTRIES
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic [W_INVD-1:0]        i_inv_delta,
    input  wire t_acc_in                  i_acc,
    input  wire logic                     i_take,
    output logic                          o_res_valid,
    output logic signed [W_GRAD-1:0]      o_res
);

    localparam int IW = $clog2(TANH_ENTRIES);
    localparam int PW = W_VAL + W_INVD;

    // Constant tanh table
    logic [W_TAB-1:0] w_tab [TANH_ENTRIES];
    for (genvar gi = 0; gi < TANH_ENTRIES; gi++) begin : g_tab
        localparam logic [63:0] ENTRY = tanh_entry(gi, TANH_ENTRIES);
        assign w_tab[gi] = ENTRY[W_TAB-1:0];
    end

    // Stage 1: centre capture or difference magnitude
    logic [W_VAL-1:0] r_centre;
    logic             r_zero;
    logic             r1_v, r1_neg, r1_edge, r1_last;
    logic [W_VAL-1:0] r1_mag;
    logic signed [W_VAL:0] w_diff;

    assign w_diff = $signed({1'b0, r_centre}) - $signed({1'b0, i_acc.word[W_VAL-1:0]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= i_acc.valid && !i_acc.centre;
        end
        if (i_acc.valid && i_acc.centre) begin
            r_centre <= i_acc.word[W_VAL-1:0];
            r_zero   <= !(i_acc.interior && i_acc.word[W_VAL]);
        end
        r1_neg  <= w_diff[W_VAL];
        r1_mag  <= w_diff[W_VAL] ? W_VAL'(-w_diff) : w_diff[W_VAL-1:0];
        r1_edge <= i_acc.edge_nb;
        r1_last <= i_acc.last;
    end

    // Stage 2: scale by inverse delta
    logic          r2_v, r2_neg, r2_edge, r2_last;
    logic [PW-1:0] r2_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_prod <= PW'(r1_mag) * PW'(i_inv_delta);
        r2_neg  <= r1_neg;
        r2_edge <= r1_edge;
        r2_last <= r1_last;
    end

    // Stage 3: table index, rounded and saturated
    logic          r3_v, r3_neg, r3_edge, r3_last;
    logic [IW-1:0] r3_idx;
    logic [63:0]   w_scaled;

    assign w_scaled = (64'(r2_prod) * 64'(TANH_ENTRIES) + (64'd1 << 22)) >> 23;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
        r3_idx  <= (w_scaled > 64'(TANH_ENTRIES - 1)) ? IW'(TANH_ENTRIES - 1) : w_scaled[IW-1:0];
        r3_neg  <= r2_neg;
        r3_edge <= r2_edge;
        r3_last <= r2_last;
    end

    // Stage 4: lookup and accumulate; sums clear when a centre arrives
    logic signed [15:0] r_s1;
    logic signed [16:0] r_s2;
    logic signed [16:0] w_t;
    logic               r4_fin;

    assign w_t = r3_neg ? -$signed({4'd0, w_tab[r3_idx]}) : $signed({4'd0, w_tab[r3_idx]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_fin <= 1'b0;
            r_s1   <= '0;
            r_s2   <= '0;
        end else begin
            r4_fin <= r3_v && r3_last;
            if (i_acc.valid && i_acc.centre) begin
                r_s1 <= '0;
                r_s2 <= '0;
            end else if (r3_v) begin
                if (r3_edge) r_s2 <= r_s2 + w_t;
                else         r_s1 <= r_s1 + 16'(w_t);
            end
        end
    end

    // Stage 5: edge weight multiply
    logic               r5_v, r5_neg, r5_zero;
    logic signed [15:0] r5_s1;
    logic [31:0]        r5_wprod;
    logic [15:0]        w_s2mag;

    assign w_s2mag = r_s2[16] ? 16'(-r_s2) : r_s2[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else begin
            r5_v <= r4_fin;
        end
        r5_wprod <= 32'(w_s2mag) * 32'(EDGE_WEIGHT);
        r5_neg   <= r_s2[16];
        r5_s1    <= r_s1;
        r5_zero  <= r_zero;
    end

    // Stage 6: round, restore sign, add face sum, saturate or force zero, hold
    logic [16:0]        w_wmag;
    logic signed [18:0] w_sum;
    logic signed [18:0] w_w;

    assign w_wmag = 17'((33'(r5_wprod) + 33'd32768) >> 16);
    assign w_w    = r5_neg ? -$signed({2'b00, w_wmag}) : $signed({2'b00, w_wmag});
    assign w_sum  = 19'(r5_s1) + w_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_res_valid <= 1'b0;
        end else if (r5_v) begin
            o_res_valid <= 1'b1;
        end else if (i_take) begin
            o_res_valid <= 1'b0;
        end
        if (r5_v) begin
            if (r5_zero)                    o_res <= '0;
            else if (w_sum > 19'sd65535)    o_res <= 17'sd65535;
            else if (w_sum < -19'sd65536)   o_res <= -17'sd65536;
            else                            o_res <= w_sum[W_GRAD-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== sv/tanh_prior_gradient_stencil.sv =====
// ============================================================================
// tanh_prior_gradient_stencil
// 18-neighbor MAP prior gradient over a raster voxel stream, with the voxel
// history held in one memory and a read sequencer feeding a tanh accumulator.
// ============================================================================
//  channel   dir  payload                          handshake
//  i_vox     in   voxel_value[23:0], in_window     valid/ready
//  o_grad    out  prior_gradient[16:0] signed,     valid/ready
//                 voxel_result
//  i_cfg_*   in   index[1:0], data[15:0]           write enable, no wait
//
//  While the history is filling an item is accepted, then loaded into the
//  output register. Once it is full an item is accepted, then its taps are
//  issued on the history read port (centre plus 18 neighbors), read from
//  memory, passed through six lookup/accumulate stages and loaded to the output.
//  The next request is taken while a result waits in the output register;
//  a result that cannot be loaded holds the sequencer until o_grad.ready.
//  Reset is synchronous; after reset or a config write the input stalls
//  while derived sizes settle. No memory clearing pass.
// ============================================================================
`default_nettype none

module tanh_prior_gradient_stencil
    import tpgs_pkg::*;
#(
    parameter int MAX_ROW_LEN  = P_MAX_ROW_LEN,
    parameter int MAX_ROWS     = P_MAX_ROWS,
    parameter int TANH_ENTRIES = P_TANH_ENTRIES
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    tpgs_in_if.sink                i_vox,
    tpgs_out_if.source             o_grad,
    input  wire logic              i_cfg_we,
    input  wire logic [W_CIDX-1:0] i_cfg_idx,
    input  wire logic [W_INVD-1:0] i_cfg_data
);

    localparam int HD  = 2 * MAX_ROWS * MAX_ROW_LEN + 2 * MAX_ROW_LEN + 3;
    localparam int AW  = $clog2(HD);
    localparam int AW1 = AW + 1;
    localparam int LW  = $clog2(MAX_ROWS * MAX_ROW_LEN + MAX_ROW_LEN + 2);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CW  = $clog2(MAX_ROW_LEN);
    localparam int YW  = $clog2(MAX_ROWS + 1);
    localparam int ZW  = $clog2(MAX_ROW_LEN + 1);
    localparam int PLW = $clog2(X_MAX);
    localparam int XW  = PLW + 1;

    // Config registers
    logic [W_CFG-1:0]  r_x_size, r_y_size, r_z_size;
    logic [W_INVD-1:0] r_inv_delta;
    logic [1:0]        r_cfg_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_size    <= RST_SIZE;
            r_y_size    <= RST_SIZE;
            r_z_size    <= RST_SIZE;
            r_inv_delta <= RST_INVD;
            r_cfg_busy  <= 2'd3;
        end else if (i_cfg_we) begin
            r_cfg_busy <= 2'd3;
            case (t_cfg_idx'(i_cfg_idx))
                CFG_X_SIZE:    r_x_size    <= i_cfg_data[W_CFG-1:0];
                CFG_Y_SIZE:    r_y_size    <= i_cfg_data[W_CFG-1:0];
                CFG_Z_SIZE:    r_z_size    <= i_cfg_data[W_CFG-1:0];
                CFG_INV_DELTA: r_inv_delta <= i_cfg_data;
                default:       ;
            endcase
        end else if (r_cfg_busy != 2'd0) begin
            r_cfg_busy <= r_cfg_busy - 2'd1;
        end
    end

    // Effective sizes, plane size and lag
    logic [XW-1:0] r_xe;
    logic [YW-1:0] r_ye;
    logic [ZW-1:0] r_ze;
    logic [LW-1:0] r_yz, r_lag;

    always_ff @(posedge i_clk) begin
        r_xe  <= (r_x_size < W_CFG'(SIZE_MIN)) ? XW'(SIZE_MIN) :
                 (32'(r_x_size) > X_MAX) ? XW'(X_MAX) : XW'(r_x_size);
        r_ye  <= (r_y_size < W_CFG'(SIZE_MIN)) ? YW'(SIZE_MIN) :
                 (32'(r_y_size) > MAX_ROWS) ? YW'(MAX_ROWS) : YW'(r_y_size);
        r_ze  <= (r_z_size < W_CFG'(SIZE_MIN)) ? ZW'(SIZE_MIN) :
                 (32'(r_z_size) > MAX_ROW_LEN) ? ZW'(MAX_ROW_LEN) : ZW'(r_z_size);
        r_yz  <= LW'(r_ye) * LW'(r_ze);
        r_lag <= r_yz + LW'(r_ze) + LW'(1);
    end

    // Sequencer state
    typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_FILL} t_state;

    t_state          r_st;
    logic [K_W-1:0]  r_k;
    logic [AW-1:0]   r_wr_ptr, r_base;
    logic [LW-1:0]   r_fill;
    logic [PLW-1:0]  r_in_pl, r_c_pl;
    logic [RW-1:0]   r_in_rw, r_c_rw;
    logic [CW-1:0]   r_in_cl, r_c_cl;
    logic            r_interior;
    logic            r_out_valid, r_out_real;
    logic signed [W_GRAD-1:0] r_out_grad;

    logic            w_acc_valid, w_take, w_out_free, w_accept, w_filled, w_out_load;
    logic signed [W_GRAD-1:0] w_acc_res;

    assign w_out_free  = !r_out_valid || o_grad.ready;
    assign i_vox.ready = (r_st == ST_IDLE) && (r_cfg_busy == 2'd0);
    assign w_accept    = i_vox.valid && i_vox.ready;
    assign w_filled    = r_fill >= r_lag;
    assign w_take      = (r_st == ST_WAIT) && w_acc_valid && w_out_free;
    assign w_out_load  = w_take || ((r_st == ST_FILL) && w_out_free);

    // Coordinate advance, wrapping at the current sizes
    logic [PLW-1:0] n_in_pl, n_c_pl;
    logic [RW-1:0]  n_in_rw, n_c_rw;
    logic [CW-1:0]  n_in_cl, n_c_cl;

    always_comb begin
        n_in_pl = r_in_pl;
        n_in_rw = r_in_rw;
        n_in_cl = r_in_cl + CW'(1);
        if (12'(r_in_cl) + 12'd1 >= 12'(r_ze)) begin
            n_in_cl = '0;
            n_in_rw = r_in_rw + RW'(1);
            if (12'(r_in_rw) + 12'd1 >= 12'(r_ye)) begin
                n_in_rw = '0;
                n_in_pl = r_in_pl + PLW'(1);
                if (12'(r_in_pl) + 12'd1 >= 12'(r_xe)) n_in_pl = '0;
            end
        end
        n_c_pl = r_c_pl;
        n_c_rw = r_c_rw;
        n_c_cl = r_c_cl + CW'(1);
        if (12'(r_c_cl) + 12'd1 >= 12'(r_ze)) begin
            n_c_cl = '0;
            n_c_rw = r_c_rw + RW'(1);
            if (12'(r_c_rw) + 12'd1 >= 12'(r_ye)) begin
                n_c_rw = '0;
                n_c_pl = r_c_pl + PLW'(1);
                if (12'(r_c_pl) + 12'd1 >= 12'(r_xe)) n_c_pl = '0;
            end
        end
    end

    // Centre lies off every boundary face
    logic w_interior;
    assign w_interior = (r_c_pl != '0) && (12'(r_c_pl) + 12'd1 < 12'(r_xe)) &&
                        (r_c_rw != '0) && (12'(r_c_rw) + 12'd1 < 12'(r_ye)) &&
                        (r_c_cl != '0) && (12'(r_c_cl) + 12'd1 < 12'(r_ze));

    // Tap offset back from the current item
    logic [AW1-1:0] n_off, r_off, w_rdiff;
    logic           r_off_v, r_off_last, r_off_centre, r_off_edge;
    logic [AW-1:0]  w_raddr;

    always_comb begin
        n_off = AW1'(r_lag);
        if (nb_dx(r_k) < 0) n_off = n_off + AW1'(r_yz);
        if (nb_dx(r_k) > 0) n_off = n_off - AW1'(r_yz);
        if (nb_dy(r_k) < 0) n_off = n_off + AW1'(r_ze);
        if (nb_dy(r_k) > 0) n_off = n_off - AW1'(r_ze);
        if (nb_dz(r_k) < 0) n_off = n_off + AW1'(1);
        if (nb_dz(r_k) > 0) n_off = n_off - AW1'(1);
    end

    assign w_rdiff = {1'b0, r_base} - r_off;
    assign w_raddr = w_rdiff[AW] ? AW'(w_rdiff + AW1'(HD)) : w_rdiff[AW-1:0];

    // Main control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_IDLE;
            r_k         <= '0;
            r_wr_ptr    <= '0;
            r_fill      <= '0;
            r_in_pl     <= '0;
            r_in_rw     <= '0;
            r_in_cl     <= '0;
            r_c_pl      <= '0;
            r_c_rw      <= '0;
            r_c_cl      <= '0;
            r_off_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load)        r_out_valid <= 1'b1;
            else if (o_grad.ready) r_out_valid <= 1'b0;
            r_off_v <= (r_st == ST_ISSUE);
            case (r_st)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_base   <= r_wr_ptr;
                        r_wr_ptr <= (32'(r_wr_ptr) == HD - 1) ? '0 : r_wr_ptr + AW'(1);
                        r_fill   <= w_filled ? r_lag : r_fill + LW'(1);
                        r_in_pl  <= n_in_pl;
                        r_in_rw  <= n_in_rw;
                        r_in_cl  <= n_in_cl;
                        r_k      <= '0;
                        if (w_filled) begin
                            r_interior <= w_interior;
                            r_c_pl     <= n_c_pl;
                            r_c_rw     <= n_c_rw;
                            r_c_cl     <= n_c_cl;
                            r_st       <= ST_ISSUE;
                        end else begin
                            r_st <= ST_FILL;
                        end
                    end
                end
                ST_ISSUE: begin
                    r_k <= r_k + K_W'(1);
                    if (32'(r_k) == NB_TAPS - 1) r_st <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (w_take) begin
                        r_out_grad <= w_acc_res;
                        r_out_real <= 1'b1;
                        r_st       <= ST_IDLE;
                    end
                end
                ST_FILL: begin
                    if (w_out_free) begin
                        r_out_grad <= '0;
                        r_out_real <= 1'b0;
                        r_st       <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
        r_off        <= n_off;
        r_off_centre <= (r_k == '0);
        r_off_last   <= (32'(r_k) == NB_TAPS - 1);
        r_off_edge   <= (32'(r_k) >= FIRST_EDGE);
    end

    // History memory and read tag
    logic [W_WORD-1:0] w_rdata;
    logic              r_rd_v, r_rd_centre, r_rd_last, r_rd_edge;

    tpgs_hist_mem #(
        .DEPTH (HD),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (r_wr_ptr),
        .i_wdata ({i_vox.in_window, i_vox.voxel_value}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
        end else begin
            r_rd_v <= r_off_v;
        end
        r_rd_centre <= r_off_centre;
        r_rd_last   <= r_off_last;
        r_rd_edge   <= r_off_edge;
    end

    // Tanh lookup and accumulation
    t_acc_in w_acc_in;

    assign w_acc_in = '{valid:    r_rd_v,
                        centre:   r_rd_centre,
                        last:     r_rd_last,
                        edge_nb:  r_rd_edge,
                        interior: r_interior,
                        word:     w_rdata};

    tpgs_tanh_acc #(
        .TANH_ENTRIES (TANH_ENTRIES)
    ) u_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_inv_delta (r_inv_delta),
        .i_acc       (w_acc_in),
        .i_take      (w_take),
        .o_res_valid (w_acc_valid),
        .o_res       (w_acc_res)
    );

    assign o_grad.valid          = r_out_valid;
    assign o_grad.prior_gradient = r_out_grad;
    assign o_grad.voxel_result   = r_out_real;

    // Checks
    a_fill_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_real) |-> (r_out_grad == '0))
        else $error("fill result carries a nonzero gradient");

    a_res_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc_valid |-> (r_st == ST_WAIT))
        else $error("accumulator result outside the wait state");

    a_one_at_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_vox.ready)
        else $error("request taken while another is in flight");

    a_reads_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_off_v |-> (32'(r_off) < HD))
        else $error("history offset beyond memory depth");

endmodule

`default_nettype wire

// ===== tb/tpgs_gradient_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tpgs_gradient_checker
// Watches the voxel, result and register ports of the prior gradient stencil.
// Keeps its own voxel history, raster counters and tanh table. It works out
// the expected gradient for every accepted voxel request. Each accepted
// result is then compared with the oldest expected one.
// ============================================================================
module tpgs_gradient_checker
    import tpgs_pkg::*;
#(
    parameter int MAX_ROW_LEN  = P_MAX_ROW_LEN,
    parameter int MAX_ROWS     = P_MAX_ROWS,
    parameter int TANH_ENTRIES = P_TANH_ENTRIES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tpgs_in_if                vox,
    tpgs_out_if               grad,
    input  logic              i_cfg_we,
    input  logic [W_CIDX-1:0] i_cfg_idx,
    input  logic [W_INVD-1:0] i_cfg_data,
    output int                o_errors,
    output int                o_pending,
    output int                o_real_seen
);

    localparam int unsigned HIST_D = 2 * MAX_ROWS * MAX_ROW_LEN + 2 * MAX_ROW_LEN + 3;

    typedef struct {
        logic signed [W_GRAD-1:0] gradient;
        logic                     real_vox;
    } t_grad_exp;

    // neighbor displacements: face neighbors in entries 0 to 5, edge neighbors in entries 6 to 17
    const int nbx[18] = '{ 0, 0,-1, 1, 0, 0, -1, 1,-1, 1,  0, 0, 0, 0, -1,-1, 1, 1};
    const int nby[18] = '{ 0, 0, 0, 0,-1, 1,  0, 0, 0, 0, -1, 1,-1, 1, -1, 1,-1, 1};
    const int nbz[18] = '{-1, 1, 0, 0, 0, 0, -1,-1, 1, 1, -1,-1, 1, 1,  0, 0, 0, 0};

    logic [W_WORD-1:0] history [HIST_D];
    logic [12:0]       tanh_q12 [TANH_ENTRIES];
    int unsigned       wr_idx, fill_cnt;
    int unsigned       in_pl, in_rw, in_cl, ctr_pl, ctr_rw, ctr_cl;
    logic [8:0]        x_sz, y_sz, z_sz;
    logic [15:0]       inv_d;
    t_grad_exp         grad_q[$];

    // tanh(8*i/N) in Q12: cubic series at a small argument, then doublings in Q30
    function automatic logic [12:0] tanh_point(int i);
        longint unsigned t, t2, t3, q;
        t  = ((longint'(i) << 21) + TANH_ENTRIES / 2) / TANH_ENTRIES;
        t2 = (t * t) >> 30;
        t3 = (t2 * t) >> 30;
        t  = t - t3 / 3;
        for (int k = 0; k < DOUBLINGS; k++)
            t = (t << 31) / ((64'd1 << 30) + ((t * t) >> 30));
        q = (t + (64'd1 << 17)) >> 18;
        if (q > ONE_Q12) q = ONE_Q12;
        return q[12:0];
    endfunction

    initial begin
        for (int i = 0; i < TANH_ENTRIES; i++) tanh_q12[i] = tanh_point(i);
        o_errors    = 0;
        o_pending   = 0;
        o_real_seen = 0;
    end

    function automatic int unsigned clamp_sz(int unsigned v, int unsigned hi);
        return v < SIZE_MIN ? SIZE_MIN : (v > hi ? hi : v);
    endfunction

    // odd tanh of a Q16.8 difference scaled by inv_delta
    function automatic int tanh_of_diff(int d);
        longint unsigned mag, idx;
        mag = d < 0 ? -d : d;
        idx = (mag * inv_d * TANH_ENTRIES + (64'd1 << 22)) >> 23;
        if (idx > TANH_ENTRIES - 1) idx = TANH_ENTRIES - 1;
        return d < 0 ? -int'(tanh_q12[idx]) : int'(tanh_q12[idx]);
    endfunction

    task automatic step_raster(inout int unsigned pl, inout int unsigned rw,
                               inout int unsigned cl, input int unsigned nx,
                               input int unsigned ny, input int unsigned nz);
        cl++;
        if (cl >= nz) begin
            cl = 0;
            rw++;
            if (rw >= ny) begin
                rw = 0;
                pl++;
                if (pl >= nx) pl = 0;
            end
        end
    endtask

    // store one voxel and queue the expected result for the lagged centre (a fill result while the history fills)
    task automatic predict_gradient(logic [W_VAL-1:0] val, logic win);
        int unsigned nx, ny, nz, yz, lag, off;
        logic [W_WORD-1:0] cw, nw;
        int s1, s2, w, sum, delta;
        longint unsigned m;
        t_grad_exp e;
        nx  = clamp_sz(x_sz, X_MAX);
        ny  = clamp_sz(y_sz, MAX_ROWS);
        nz  = clamp_sz(z_sz, MAX_ROW_LEN);
        yz  = ny * nz;
        lag = yz + nz + 1;
        e.gradient = '0;
        e.real_vox = 1'b0;
        history[wr_idx] = {win, val};
        if (fill_cnt >= lag) begin
            cw = history[(wr_idx + HIST_D - lag) % HIST_D];
            e.real_vox = 1'b1;
            if (cw[W_VAL] && ctr_pl >= 1 && ctr_pl + 1 < nx && ctr_rw >= 1 && ctr_rw + 1 < ny
                    && ctr_cl >= 1 && ctr_cl + 1 < nz) begin
                s1 = 0;
                s2 = 0;
                for (int k = 0; k < 18; k++) begin
                    delta = nbx[k] * int'(yz) + nby[k] * int'(nz) + nbz[k];
                    off   = int'(lag) - delta;
                    nw    = history[(wr_idx + HIST_D - off) % HIST_D];
                    if (k < 6) s1 += tanh_of_diff(int'(cw[W_VAL-1:0]) - int'(nw[W_VAL-1:0]));
                    else       s2 += tanh_of_diff(int'(cw[W_VAL-1:0]) - int'(nw[W_VAL-1:0]));
                end
                m   = s2 < 0 ? -s2 : s2;
                m   = (m * EDGE_WEIGHT + 32768) >> 16;
                w   = s2 < 0 ? -int'(m) : int'(m);
                sum = s1 + w;
                if (sum > 65535)  sum = 65535;
                if (sum < -65536) sum = -65536;
                e.gradient = sum[W_GRAD-1:0];
            end
            step_raster(ctr_pl, ctr_rw, ctr_cl, nx, ny, nz);
        end
        if (fill_cnt < lag) fill_cnt++;
        else                fill_cnt = lag;
        step_raster(in_pl, in_rw, in_cl, nx, ny, nz);
        wr_idx = (wr_idx + 1) % HIST_D;
        grad_q.push_back(e);
    endtask

    always @(posedge i_clk) begin
        t_grad_exp e;
        if (!i_rst_n) begin
            wr_idx = 0; fill_cnt = 0;
            in_pl = 0; in_rw = 0; in_cl = 0;
            ctr_pl = 0; ctr_rw = 0; ctr_cl = 0;
            x_sz = RST_SIZE; y_sz = RST_SIZE; z_sz = RST_SIZE; inv_d = RST_INVD;
            grad_q.delete();
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_X_SIZE:    x_sz  = i_cfg_data[8:0];
                    CFG_Y_SIZE:    y_sz  = i_cfg_data[8:0];
                    CFG_Z_SIZE:    z_sz  = i_cfg_data[8:0];
                    CFG_INV_DELTA: inv_d = i_cfg_data;
                    default: ;
                endcase
            end
            if (vox.valid && vox.ready) predict_gradient(vox.voxel_value, vox.in_window);
            // result compare against the oldest expectation
            if (grad.valid && grad.ready) begin
                if (grad_q.size() == 0) begin
                    $error("unexpected result: prior_gradient %0d voxel_result %0b",
                           grad.prior_gradient, grad.voxel_result);
                    o_errors++;
                end else begin
                    e = grad_q.pop_front();
                    if (grad.prior_gradient !== e.gradient) begin
                        $error("prior_gradient: expected %0d, actual %0d",
                               e.gradient, grad.prior_gradient);
                        o_errors++;
                    end
                    if (grad.voxel_result !== e.real_vox) begin
                        $error("voxel_result: expected %0b, actual %0b",
                               e.real_vox, grad.voxel_result);
                        o_errors++;
                    end
                    if (e.real_vox) o_real_seen++;
                end
            end
        end
        o_pending = grad_q.size();
    end

endmodule

// ===== tb/tb_tanh_prior_gradient_stencil.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_tanh_prior_gradient_stencil
// Streams raster voxel volumes through the stencil under several size and
// scale settings, with random idling on both channels. A long output stall
// is included. The checker beside the block predicts every result.
// ============================================================================
module tb_tanh_prior_gradient_stencil;
    import tpgs_pkg::*;

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_we;
    logic [W_CIDX-1:0] cfg_idx;
    logic [W_INVD-1:0] cfg_data;
    int                errors, pending, real_seen, n_sent;
    logic              tx_gaps, rx_gaps, hold_req;
    logic [W_VAL-1:0]  base_val;

    tpgs_in_if  vox_if ();
    tpgs_out_if grad_if ();

    tanh_prior_gradient_stencil dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vox      (vox_if),
        .o_grad     (grad_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    tpgs_gradient_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .vox         (vox_if),
        .grad        (grad_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_real_seen (real_seen)
    );

    always #5 i_clk = ~i_clk;

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // values near a running base so tanh stays off its rails, plus noise and extremes
    function automatic logic [W_VAL-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 70) return W_VAL'(32'(base_val) + $urandom_range(3000) - 32'd1500);
        if (r < 90) return W_VAL'($urandom());
        return r[0] ? {W_VAL{1'b1}} : '0;
    endfunction

    task automatic send_voxel(logic [W_VAL-1:0] val, logic win);
        int g;
        g = tx_gaps ? gap_len() : 0;
        if (g > 0) begin
            vox_if.valid = 1'b0;
            repeat (g) @(negedge i_clk);
        end
        vox_if.valid       = 1'b1;
        vox_if.voxel_value = val;
        vox_if.in_window   = win;
        do @(posedge i_clk); while (!vox_if.ready);
        @(negedge i_clk);
        vox_if.valid = 1'b0;
        n_sent++;
    endtask

    task automatic send_random(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(63) == 0) base_val = W_VAL'($urandom());
            send_voxel(pick_value(), $urandom_range(9) != 0);
        end
    endtask

    // wait for all results, then for any work still inside the block
    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [W_INVD-1:0] val);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = val;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_sizes(logic [8:0] nx, logic [8:0] ny, logic [8:0] nz,
                             logic [15:0] inv);
        write_reg(CFG_X_SIZE, W_INVD'(nx));
        write_reg(CFG_Y_SIZE, W_INVD'(ny));
        write_reg(CFG_Z_SIZE, W_INVD'(nz));
        write_reg(CFG_INV_DELTA, inv);
        repeat (4) @(negedge i_clk);
    endtask

    // result side ready, with one long hold-off on request
    initial begin
        int g;
        grad_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req      = 1'b0;
                grad_if.ready = 1'b0;
                repeat (600) @(negedge i_clk);
            end else begin
                g = rx_gaps ? gap_len() : 0;
                if (g > 0) begin
                    grad_if.ready = 1'b0;
                    repeat (g - 1) @(negedge i_clk);
                end else begin
                    grad_if.ready = 1'b1;
                end
            end
        end
    end

    // run limit
    initial begin
        #50ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // stimulus
    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_X_SIZE;
        cfg_data = '0;
        vox_if.valid = 1'b0;
        vox_if.voxel_value = '0;
        vox_if.in_window = 1'b0;
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        hold_req = 1'b0;
        n_sent = 0;
        base_val = 24'h400000;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (4) @(negedge i_clk);

        // smallest cube; only the middle voxel is interior
        set_sizes(9'd3, 9'd3, 9'd3, 16'd4096);
        for (int i = 0; i < 27; i++)
            send_voxel(i == 13 ? {W_VAL{1'b1}} : (i[0] ? 24'd0 : 24'hFFFF00), 1'b1);
        // same cube, centre at zero with full-scale neighbors, then centre out of window
        for (int i = 0; i < 27; i++)
            send_voxel(i == 13 ? 24'd0 : {W_VAL{1'b1}}, 1'b1);
        for (int i = 0; i < 27; i++)
            send_voxel(W_VAL'(24'h000100 * i), i != 13);
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        send_random(20);
        drain();

        // x below range clamps, largest scale
        set_sizes(9'd0, 9'd4, 9'd5, 16'hFFFF);
        send_random(150);
        drain();
        send_random(150);
        drain();

        // x above range clamps, zero scale
        set_sizes(9'h1FF, 9'd5, 9'd3, 16'd0);
        tx_gaps = 1'b0;
        send_random(200);
        drain();

        // long output stall while requests keep coming
        set_sizes(9'd6, 9'd6, 9'd6, 16'($urandom_range(16384, 512)));
        tx_gaps = 1'b1;
        send_random(50);
        hold_req = 1'b1;
        rx_gaps  = 1'b0;
        send_random(150);
        rx_gaps = 1'b1;
        drain();

        // largest row length, fewest rows, widest plane count
        set_sizes(9'd256, 9'd0, 9'h1FF, 16'd4096);
        send_random(800);

        drain();
        $display("Sent %0d voxel requests across five size and scale settings,", n_sent);
        $display("%0d real-voxel gradients were checked along with fill results.", real_seen);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/tpgs_pkg.sv
sv/tpgs_in_if.sv
sv/tpgs_out_if.sv
sv/tpgs_hist_mem.sv
sv/tpgs_tanh_acc.sv
sv/tanh_prior_gradient_stencil.sv
tb/tpgs_gradient_checker.sv
tb/tb_tanh_prior_gradient_stencil.sv
